### rtl/core/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, widths and constants of the Taylor sine/cosine block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // series length cap (terms per series, first term included)
  localparam int MAX_TERMS = 16;

  localparam int ANGLE_W   = 18;
  localparam int DMAG_W    = ANGLE_W - 1;
  localparam int OUT_W     = 32;
  localparam int ACC_W     = 31;
  localparam int K_W       = $clog2(MAX_TERMS);
  localparam int DIV_W     = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);

  localparam int MAG_W       = 40;
  localparam int X2_W        = 36;
  localparam int MUL_A_W     = 40;
  localparam int MUL_SLICE_W = 18;
  localparam int MUL_B_W     = 2 * MUL_SLICE_W;
  localparam int PP_W        = MUL_A_W + MUL_SLICE_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int DVD_W      = 44;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DVD_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  localparam int SUM_W      = 44;
  localparam int CONV_SHIFT = 10;
  localparam int Q_SHIFT    = 30;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // pi/180 in Q32
  localparam logic [MUL_A_W-1:0]        DEG_TO_RAD_Q32  = 40'd74961321;
  localparam logic signed [ANGLE_W-1:0] ANGLE_CLAMP     = 18'sd92160;
  localparam logic signed [ANGLE_W-1:0] ANGLE_CLAMP_NEG = -18'sd92160;
  localparam logic [MAG_W-1:0]          ONE_MAG         = 40'h0040000000;
  localparam logic signed [SUM_W-1:0]   ONE_SUM         = 44'sh00040000000;
  localparam logic signed [OUT_W-1:0]   ONE_OUT         = 32'sh40000000;
  localparam logic [ACC_W-1:0]          ACC_RESET       = 31'd107374;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_ACCURACY_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SQ_START,
    ST_SQ,
    ST_TMUL_START,
    ST_TMUL,
    ST_TDIV,
    ST_TACC,
    ST_DONE
  } tsc_state_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_SUM
  } mul_phase_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // k(k+1) style divisor of term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic logic [DIV_W-1:0] term_divisor(input logic [K_W-1:0] k,
                                                    input logic is_cos);
    logic [K_W+1:0]   n;
    logic [K_W+1:0]   np1;
    logic [2*K_W+3:0] d;
    n   = {1'b0, k, 1'b0} - {{(K_W + 1){1'b0}}, is_cos};
    np1 = n + {{(K_W + 1){1'b0}}, 1'b1};
    d   = {{(K_W + 2){1'b0}}, n} * {{(K_W + 2){1'b0}}, np1};
    return d[DIV_W-1:0];
  endfunction

endpackage

### rtl/core/tsc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_mul
// Shared multiplier: A x B in two 18-bit slices of B, accumulated over cycles.
// ----------------------------------------------------------------------------
module tsc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  tsc_pkg::mul_req_t req,
  output tsc_pkg::mul_rsp_t rsp
);
  import tsc_pkg::*;

  mul_phase_t         phase_r, phase_nxt;
  logic               done_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [PP_W-1:0]    pp_r;
  logic [PROD_W-1:0]  acc_r;

  always_comb begin
    case (phase_r)
      MP_IDLE: phase_nxt = req.start ? MP_LO : MP_IDLE;
      MP_LO:   phase_nxt = MP_HI;
      MP_HI:   phase_nxt = MP_SUM;
      MP_SUM:  phase_nxt = MP_IDLE;
      default: phase_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == MP_SUM);
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      MP_IDLE: begin
        if (req.start) begin
          a_r <= req.a;
          b_r <= req.b;
        end
      end
      MP_LO: pp_r <= PP_W'(a_r) * PP_W'(b_r[MUL_SLICE_W-1:0]);
      MP_HI: begin
        acc_r <= {{(PROD_W - PP_W){1'b0}}, pp_r};
        pp_r  <= PP_W'(a_r) * PP_W'(b_r[MUL_B_W-1:MUL_SLICE_W]);
      end
      MP_SUM: acc_r <= acc_r + ({{(PROD_W - PP_W){1'b0}}, pp_r} << MUL_SLICE_W);
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### rtl/core/tsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_div
// Restoring divider, DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tsc_pkg::div_req_t req,
  output tsc_pkg::div_rsp_t rsp
);
  import tsc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r;
  logic [DVD_W-1:0]     quo_r, quo_nxt;

  // dividend bits shift out of the top of quo_r, quotient bits enter at the bottom
  always_comb begin : div_steps
    logic [DIV_W:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial   = {rem_nxt, quo_nxt[DVD_W-1]};
      quo_nxt = {quo_nxt[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end else if (req.start) begin
        cnt_r <= DIV_CNT_W'(DIV_CYCLES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end else if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### rtl/core/tsc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_core
// Sequencer and term datapath; drives the shared multiplier and divider.
// ----------------------------------------------------------------------------
module tsc_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsc_pkg::ANGLE_W-1:0]  in_angle,
  input  logic [tsc_pkg::ACC_W-1:0]           acc_limit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_sine,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_cosine,
  output logic                                out_hit
);
  import tsc_pkg::*;

  tsc_state_t state_r, state_nxt;
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic                      neg_x_r;
  logic [MAG_W-1:0]          xmag_r;
  logic [X2_W-1:0]           x2_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [K_W-1:0]            k_r;
  logic                      is_cos_r;
  logic                      hit_r;
  logic signed [OUT_W-1:0]   sine_r;
  logic signed [OUT_W-1:0]   cosine_r;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_sine_r;
  logic signed [OUT_W-1:0]   out_cosine_r;
  logic                      out_hit_r;

  logic signed [ANGLE_W-1:0] deg_clamped;
  logic signed [ANGLE_W-1:0] deg_abs;
  logic [DMAG_W-1:0]         dmag;
  logic [PROD_W-1:0]         prod_rnd_conv;
  logic [PROD_W-1:0]         prod_rnd_q30;
  logic [MAG_W-1:0]          xmag_conv;
  logic [X2_W-1:0]           x2_val;
  logic [DVD_W-1:0]          mul_q30;
  logic [DIV_W-1:0]          divisor;
  logic signed [SUM_W-1:0]   xsum;
  logic signed [SUM_W-1:0]   term_signed;
  logic signed [SUM_W-1:0]   sum_add;
  logic                      term_small;
  logic                      term_last;
  logic                      out_load;

  function automatic logic signed [OUT_W-1:0] sat_one(input logic signed [SUM_W-1:0] v);
    if (v > ONE_SUM) begin
      return ONE_OUT;
    end else if (v < -ONE_SUM) begin
      return -ONE_OUT;
    end else begin
      return $signed(v[OUT_W-1:0]);
    end
  endfunction

  tsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  tsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // angle clamp and magnitude
  always_comb begin
    if (in_angle > ANGLE_CLAMP) begin
      deg_clamped = ANGLE_CLAMP;
    end else if (in_angle < ANGLE_CLAMP_NEG) begin
      deg_clamped = ANGLE_CLAMP_NEG;
    end else begin
      deg_clamped = in_angle;
    end
    deg_abs = deg_clamped[ANGLE_W-1] ? -deg_clamped : deg_clamped;
    dmag    = deg_abs[DMAG_W-1:0];
  end

  // round half up, then drop the fraction
  assign prod_rnd_conv = mul_rsp.prod + (PROD_W'(1) << (CONV_SHIFT - 1));
  assign prod_rnd_q30  = mul_rsp.prod + (PROD_W'(1) << (Q_SHIFT - 1));
  assign xmag_conv     = prod_rnd_conv[CONV_SHIFT +: MAG_W];
  assign x2_val        = prod_rnd_q30[Q_SHIFT +: X2_W];
  assign mul_q30       = prod_rnd_q30[Q_SHIFT +: DVD_W];
  assign divisor       = term_divisor(k_r, is_cos_r);

  assign xsum        = neg_x_r ? -$signed({{(SUM_W - MAG_W){1'b0}}, xmag_r})
                               :  $signed({{(SUM_W - MAG_W){1'b0}}, xmag_r});
  assign term_signed = neg_r ? -$signed({{(SUM_W - MAG_W){1'b0}}, mag_r})
                             :  $signed({{(SUM_W - MAG_W){1'b0}}, mag_r});
  assign sum_add     = sum_r + term_signed;
  assign term_small  = ({{(MAG_W - ACC_W){1'b0}}, acc_limit} >= mag_r);
  assign term_last   = (k_r == K_W'(MAX_TERMS - 1));
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_CONV;
      ST_CONV:       if (mul_rsp.done) state_nxt = ST_SQ_START;
      ST_SQ_START:   state_nxt = ST_SQ;
      ST_SQ:         if (mul_rsp.done) state_nxt = ST_TMUL_START;
      ST_TMUL_START: state_nxt = ST_TMUL;
      ST_TMUL:       if (mul_rsp.done) state_nxt = ST_TDIV;
      ST_TDIV:       if (div_rsp.done) state_nxt = ST_TACC;
      ST_TACC: begin
        if ((term_small || term_last) && is_cos_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_TMUL_START;
        end
      end
      ST_DONE:       if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    in_ready         = 1'b0;
    mul_req.start    = 1'b0;
    mul_req.a        = mag_r;
    mul_req.b        = x2_r;
    div_req.start    = 1'b0;
    div_req.dividend = mul_q30 + DVD_W'(divisor >> 1);
    div_req.divisor  = divisor;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        mul_req.start = in_valid;
        mul_req.a     = DEG_TO_RAD_Q32;
        mul_req.b     = {{(MUL_B_W - DMAG_W){1'b0}}, dmag};
      end
      ST_SQ_START: begin
        mul_req.start = 1'b1;
        mul_req.a     = xmag_r;
        mul_req.b     = xmag_r[MUL_B_W-1:0];
      end
      ST_TMUL_START: mul_req.start = 1'b1;
      ST_TMUL:       div_req.start = mul_rsp.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_x_r <= deg_clamped[ANGLE_W-1];
        end
      end
      ST_CONV: begin
        if (mul_rsp.done) begin
          xmag_r <= xmag_conv;
        end
      end
      ST_SQ: begin
        // sine series starts from x itself
        if (mul_rsp.done) begin
          x2_r     <= x2_val;
          mag_r    <= xmag_r;
          neg_r    <= neg_x_r;
          sum_r    <= xsum;
          k_r      <= K_W'(1);
          is_cos_r <= 1'b0;
          hit_r    <= 1'b0;
        end
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          mag_r <= div_rsp.quotient[MAG_W-1:0];
          neg_r <= !neg_r;
        end
      end
      ST_TACC: begin
        if (term_small || term_last) begin
          if (!term_small) begin
            hit_r <= 1'b1;
          end
          if (!is_cos_r) begin
            // sine done, cosine series starts from one
            sine_r   <= sat_one(sum_add);
            mag_r    <= ONE_MAG;
            neg_r    <= 1'b0;
            sum_r    <= ONE_SUM;
            k_r      <= K_W'(1);
            is_cos_r <= 1'b1;
          end else begin
            sum_r    <= sum_add;
            cosine_r <= sat_one(sum_add);
          end
        end else begin
          sum_r <= sum_add;
          k_r   <= k_r + K_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sine_r   <= sine_r;
      out_cosine_r <= cosine_r;
      out_hit_r    <= hit_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;
  assign out_hit    = out_hit_r;

endmodule

### rtl/core/taylor_sine_cosine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Sine and cosine of an angle in degrees by Taylor series, Q2.30 results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one angle per request, degrees with 8 fraction bits, clamped to
//            +-360.0 inside the block.
//   out_*  : sine and cosine in Q2.30, saturated to +-1, plus a flag set when
//            either series reached the term cap without converging.
//   cfg_*  : APB register 0 = accuracy limit (term magnitude stop, Q2.30).
//   Terms:   T, the number of terms computed after the first in both series,
//            lies in 2 to 2*(MAX_TERMS-1), 2 to 30 at MAX_TERMS = 16.
//            Each term is one pass of the shared 40x18 multiplier
//            and one pass of the 4-bit-per-cycle divider.
//   One request is in flight at a time; in_tready is high only while the
//   sequencer is idle. A finished result sits in the output register, and the
//   next request is taken while it waits; a stalled receiver holds the block
//   in its final step once a second result is ready.
//   Reset clears the sequencer and out_tvalid; accuracy limit returns to 0.0001.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tsc_pkg::IN_TDATA_W-1:0]       in_tdata,    // [17:0] angle_degrees
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tsc_pkg::OUT_TDATA_W-1:0]      out_tdata,   // [31:0] sine_value, [63:32] cosine_value
  output logic [0:0]                           out_tuser,   // [0] term_limit_hit
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tsc_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [tsc_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);
  import tsc_pkg::*;

  logic [ACC_W-1:0]        acc_limit_r;
  logic                    acc_sel;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;
  logic                    hit;

  assign cfg_pready = 1'b1;
  assign acc_sel    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_ACCURACY_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_limit_r <= ACC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && acc_sel) begin
      acc_limit_r <= cfg_pwdata[ACC_W-1:0];
    end
  end

  assign cfg_prdata = acc_sel ? {{(CFG_DATA_W - ACC_W){1'b0}}, acc_limit_r} : '0;

  tsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_angle   ($signed(in_tdata[ANGLE_W-1:0])),
    .acc_limit  (acc_limit_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sine   (sine),
    .out_cosine (cosine),
    .out_hit    (hit)
  );

  assign out_tdata = {cosine, sine};
  assign out_tuser = hit;

endmodule

### rtl/core/tsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the Taylor sine/cosine block, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // one request at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted request");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // both results saturated to +-1.0 in Q2.30
  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= 32'sh40000000)
               && ($signed(out_tdata[31:0]) >= -32'sh40000000)
               && ($signed(out_tdata[63:32]) <= 32'sh40000000)
               && ($signed(out_tdata[63:32]) >= -32'sh40000000))
    else $error("result outside +-1.0");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

endmodule

bind taylor_sine_cosine_top tsc_checker u_tsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
